### src/adsr_pkg.sv
`timescale 1ns / 1ps

package adsr_pkg;

  // fixed-point formats
  localparam int unsigned LEVEL_FRAC_BITS = 23;
  localparam int unsigned COEFF_FRAC_BITS = 24;
  localparam int unsigned LEVEL_W = LEVEL_FRAC_BITS + 1;
  localparam int unsigned COEFF_W = 24;
  localparam int unsigned REG_W   = 24;
  localparam int unsigned VEL_W   = 7;
  localparam int unsigned GAIN_W  = 15;
  localparam int unsigned STAGE_W = 3;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned IDX_W   = 3;

  localparam longint unsigned FULL_INT = 64'd1 << LEVEL_FRAC_BITS;
  localparam logic [LEVEL_W-1:0] FULL_LEVEL  = LEVEL_W'(FULL_INT);
  localparam logic [LEVEL_W-1:0] ATTACK_SNAP = LEVEL_W'((FULL_INT * 999) / 1000);
  localparam logic [LEVEL_W-1:0] DECAY_EPS   = LEVEL_W'(FULL_INT / 1000);

  // item kinds
  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NOTE_ON = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

  // envelope stage codes
  localparam logic [STAGE_W-1:0] STAGE_IDLE    = 3'd0;
  localparam logic [STAGE_W-1:0] STAGE_ATTACK  = 3'd1;
  localparam logic [STAGE_W-1:0] STAGE_DECAY   = 3'd2;
  localparam logic [STAGE_W-1:0] STAGE_SUSTAIN = 3'd3;
  localparam logic [STAGE_W-1:0] STAGE_RELEASE = 3'd4;

  // register indexes
  localparam logic [IDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [IDX_W-1:0] REG_DECAY   = 3'd1;
  localparam logic [IDX_W-1:0] REG_RELEASE = 3'd2;
  localparam logic [IDX_W-1:0] REG_SUSTAIN = 3'd3;
  localparam logic [IDX_W-1:0] REG_SILENCE = 3'd4;

  // register reset values
  localparam logic [REG_W-1:0] ATTACK_RST  = 24'd126333;
  localparam logic [REG_W-1:0] DECAY_RST   = 24'd4755;
  localparam logic [REG_W-1:0] RELEASE_RST = 24'd16748040;
  localparam logic [REG_W-1:0] SUSTAIN_RST = 24'd6543114;
  localparam logic [REG_W-1:0] SILENCE_RST = 24'd84;

  localparam logic [VEL_W-1:0] VEL_MIN = 7'd1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [VEL_W-1:0]  note_velocity;
    logic              legato_slide;
    logic              pitch_valid;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] envelope_level;
    logic [GAIN_W-1:0]  velocity_gain;
    logic [STAGE_W-1:0] envelope_stage;
    logic               voice_active;
  } result_t;

  typedef struct packed {
    logic [IDX_W-1:0] reg_index;
    logic [REG_W-1:0] reg_value;
  } cfg_wr_t;

  typedef struct packed {
    logic [COEFF_W-1:0] attack_coeff;
    logic [COEFF_W-1:0] decay_coeff;
    logic [COEFF_W-1:0] release_coeff;
    logic [REG_W-1:0]   sustain_level;
    logic [REG_W-1:0]   silence_level;
  } cfg_t;

  // velocity to gain, round half up of vel * 0.00375 in Q0.16
  typedef logic [(2**VEL_W)-1:0][GAIN_W-1:0] gain_lut_t;

  function automatic gain_lut_t build_gain_lut();
    gain_lut_t   lut;
    int unsigned v;
    for (int i = 0; i < 2**VEL_W; i++) begin
      v = (i * 24576 + 50) / 100;
      lut[i] = v[GAIN_W-1:0];
    end
    return lut;
  endfunction

  localparam gain_lut_t GAIN_LUT = build_gain_lut();

endpackage

### src/adsr_if.sv
`timescale 1ns / 1ps

interface adsr_item_if;
  logic            valid;
  logic            ready;
  adsr_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface adsr_result_if;
  logic              valid;
  logic              ready;
  adsr_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface adsr_cfg_if;
  logic              valid;
  logic              ready;
  adsr_pkg::cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/adsr_cfg_regs.sv
`timescale 1ns / 1ps

module adsr_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  adsr_cfg_if.sink       cfg_i,
  output adsr_pkg::cfg_t cfg_o
);
  import adsr_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_coeff  <= ATTACK_RST;
      cfg_q.decay_coeff   <= DECAY_RST;
      cfg_q.release_coeff <= RELEASE_RST;
      cfg_q.sustain_level <= SUSTAIN_RST;
      cfg_q.silence_level <= SILENCE_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.reg_index)
        REG_ATTACK:  cfg_q.attack_coeff  <= cfg_i.data.reg_value;
        REG_DECAY:   cfg_q.decay_coeff   <= cfg_i.data.reg_value;
        REG_RELEASE: cfg_q.release_coeff <= cfg_i.data.reg_value;
        REG_SUSTAIN: cfg_q.sustain_level <= cfg_i.data.reg_value;
        REG_SILENCE: cfg_q.silence_level <= cfg_i.data.reg_value;
        default: ;
      endcase
    end
  end

endmodule

### src/adsr_voice.sv
`timescale 1ns / 1ps

module adsr_voice (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_en_i,
  input  adsr_pkg::item_t   item_i,
  input  adsr_pkg::cfg_t    cfg_i,
  output adsr_pkg::result_t result_o
);
  import adsr_pkg::*;

  logic               gate_q, gate_d;
  logic [STAGE_W-1:0] stage_q, stage_d;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic [VEL_W-1:0]   vel_q, vel_d;

  // state after a note-on or release event
  logic               ev_gate;
  logic [STAGE_W-1:0] ev_stage;
  logic [LEVEL_W-1:0] ev_level;
  logic [VEL_W-1:0]   ev_vel;

  // one envelope step from the current state
  logic [STAGE_W-1:0]         adv_pre;
  logic [STAGE_W-1:0]         adv_stage;
  logic [LEVEL_W-1:0]         adv_level;
  logic [VEL_W-1:0]           adv_vel;
  logic [LEVEL_W-1:0]         sus_lvl, sil_lvl;
  logic [LEVEL_W-1:0]         mul_a;
  logic [COEFF_W-1:0]         mul_c;
  logic [LEVEL_W+COEFF_W-1:0] prod;
  logic [LEVEL_W-1:0]         step;
  logic [LEVEL_W:0]           sum_up;
  logic [LEVEL_W-1:0]         dec_lvl;
  logic [LEVEL_W:0]           sus_eps;
  logic                       active;

  assign sus_lvl = (cfg_i.sustain_level > FULL_LEVEL) ? FULL_LEVEL : cfg_i.sustain_level;
  assign sil_lvl = (cfg_i.silence_level > FULL_LEVEL) ? FULL_LEVEL : cfg_i.silence_level;
  assign sus_eps = {1'b0, sus_lvl} + {1'b0, DECAY_EPS};

  always_comb begin
    ev_gate  = gate_q;
    ev_stage = stage_q;
    ev_level = level_q;
    ev_vel   = vel_q;
    unique case (item_i.mode)
      MODE_NOTE_ON: begin
        if (item_i.pitch_valid &&
            !(item_i.legato_slide && gate_q && (stage_q != STAGE_IDLE))) begin
          ev_gate  = 1'b1;
          ev_vel   = (item_i.note_velocity < VEL_MIN) ? VEL_MIN : item_i.note_velocity;
          ev_level = '0;
          ev_stage = STAGE_ATTACK;
        end
      end
      MODE_RELEASE: begin
        ev_gate = 1'b0;
        if (stage_q != STAGE_IDLE) begin
          ev_stage = STAGE_RELEASE;
        end
      end
      default: ;
    endcase
  end

  // gate dropped during attack, decay or sustain goes straight to release
  always_comb begin
    adv_pre = stage_q;
    if (!gate_q && (stage_q == STAGE_ATTACK || stage_q == STAGE_DECAY ||
                    stage_q == STAGE_SUSTAIN)) begin
      adv_pre = STAGE_RELEASE;
    end
  end

  // shared multiplier operands
  always_comb begin
    unique case (adv_pre)
      STAGE_ATTACK: begin
        mul_a = FULL_LEVEL - level_q;
        mul_c = cfg_i.attack_coeff;
      end
      STAGE_DECAY: begin
        mul_a = (level_q >= sus_lvl) ? (level_q - sus_lvl) : (sus_lvl - level_q);
        mul_c = cfg_i.decay_coeff;
      end
      STAGE_RELEASE: begin
        mul_a = level_q;
        mul_c = cfg_i.release_coeff;
      end
      default: begin
        mul_a = '0;
        mul_c = '0;
      end
    endcase
  end

  assign prod    = mul_a * mul_c;
  assign step    = prod[COEFF_FRAC_BITS +: LEVEL_W];
  assign sum_up  = {1'b0, level_q} + {1'b0, step};
  assign dec_lvl = (level_q >= sus_lvl) ? (level_q - step) : sum_up[LEVEL_W-1:0];

  always_comb begin
    adv_stage = adv_pre;
    adv_level = '0;
    adv_vel   = vel_q;
    unique case (adv_pre)
      STAGE_ATTACK: begin
        if (sum_up >= {1'b0, ATTACK_SNAP}) begin
          adv_level = FULL_LEVEL;
          adv_stage = STAGE_DECAY;
        end else begin
          adv_level = sum_up[LEVEL_W-1:0];
        end
      end
      STAGE_DECAY: begin
        if ({1'b0, dec_lvl} <= sus_eps) begin
          adv_level = sus_lvl;
          adv_stage = STAGE_SUSTAIN;
        end else begin
          adv_level = dec_lvl;
        end
      end
      STAGE_SUSTAIN: adv_level = sus_lvl;
      STAGE_RELEASE: begin
        if (step <= sil_lvl) begin
          adv_level = '0;
          adv_vel   = '0;
          adv_stage = STAGE_IDLE;
        end else begin
          adv_level = step;
        end
      end
      default: adv_level = '0;
    endcase
  end

  always_comb begin
    gate_d  = gate_q;
    stage_d = stage_q;
    level_d = level_q;
    vel_d   = vel_q;
    if (item_en_i) begin
      if (item_i.mode == MODE_TICK) begin
        stage_d = adv_stage;
        level_d = adv_level;
        vel_d   = adv_vel;
      end else begin
        gate_d  = ev_gate;
        stage_d = ev_stage;
        level_d = ev_level;
        vel_d   = ev_vel;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q  <= 1'b0;
      stage_q <= STAGE_IDLE;
      level_q <= '0;
      vel_q   <= '0;
    end else begin
      gate_q  <= gate_d;
      stage_q <= stage_d;
      level_q <= level_d;
      vel_q   <= vel_d;
    end
  end

  // a tick reports the state before its advance, which equals the event state
  assign active = (ev_stage >= STAGE_ATTACK) && (ev_stage <= STAGE_RELEASE);

  always_comb begin
    result_o.envelope_level = ev_level;
    result_o.velocity_gain  = active ? GAIN_LUT[ev_vel] : '0;
    result_o.envelope_stage = ev_stage;
    result_o.voice_active   = active;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_q == STAGE_IDLE) |-> (level_q == '0))
    else $error("idle voice holds a nonzero level");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_q == STAGE_IDLE) |-> (vel_q == '0))
    else $error("idle voice holds a velocity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !gate_q |-> (stage_q == STAGE_IDLE || stage_q == STAGE_RELEASE))
    else $error("gate low outside release or idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= FULL_LEVEL)
    else $error("level above full scale");

endmodule

### src/exponential_adsr_envelope.sv
// item_i beats pass the input register, then the output register, to reach result_o
// throughput: one item per cycle while result_o is ready; the path is one 24x24 multiply plus add and compare
// a waiting result holds the item in the input register; input stalls only when both are full
// reset clears the voice (idle, gate low, level and velocity zero) and the pipeline,
// and loads the default attack, decay, release, sustain and silence registers
`timescale 1ns / 1ps

module exponential_adsr_envelope (
  input  logic          clk_i,
  input  logic          rst_ni,
  adsr_item_if.sink     item_i,
  adsr_result_if.source result_o,
  adsr_cfg_if.sink      cfg_i
);
  import adsr_pkg::*;

  // input register
  logic    in_valid_q, in_valid_d;
  item_t   item_q;

  // output register
  logic    out_valid_q, out_valid_d;
  result_t result_q;

  cfg_t    cfg;
  result_t step_result;
  logic    out_free;
  logic    advance;
  logic    item_take;

  // output slot is free when empty or being drained this cycle
  assign out_free  = !out_valid_q || result_o.ready;
  // the held item is processed and its result registered
  assign advance   = in_valid_q && out_free;
  assign item_take = item_i.valid && item_i.ready;

  assign item_i.ready   = !in_valid_q || out_free;
  assign result_o.valid = out_valid_q;
  assign result_o.data  = result_q;

  adsr_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // voice state updates on the same edge that captures the result
  adsr_voice u_voice (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_en_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg),
    .result_o  (step_result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (item_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload beats, no reset needed
  always_ff @(posedge clk_i) begin
    if (item_take) begin
      item_q <= item_i.data;
    end
    if (advance) begin
      result_q <= step_result;
    end
  end

endmodule
